/* design/ilbmrle_pkg.sv */
// package for the ilbm body run unpacker
// holds field widths, default sizes, register indexes, reset values, header codes and the decode phase type
// no dependencies
package ilbmrle_pkg;

	localparam int CFG_DATA_W     = 11;
	localparam int CFG_IDX_W      = 3;
	localparam int OFS_W          = 20;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [CFG_DATA_W-1:0] RST_SRC_WIDTH  = 11'd320;
	localparam logic [CFG_DATA_W-1:0] RST_SRC_HEIGHT = 11'd240;
	localparam logic [CFG_DATA_W-1:0] RST_CLIP_WIDTH = 11'd320;
	localparam logic [CFG_DATA_W-1:0] RST_CLIP_HEIGHT = 11'd240;

	localparam logic [7:0] HDR_NOP = 8'd128;
	localparam logic [8:0] REP_BIAS = 9'd257;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH   = 3'd0,
		REG_SRC_HEIGHT  = 3'd1,
		REG_CLIP_WIDTH  = 3'd2,
		REG_CLIP_HEIGHT = 3'd3,
		REG_COMPRESSED  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LITERAL = 2'd1,
		PH_REPEAT  = 2'd2,
		PH_DISCARD = 2'd3
	} phase_t;

endpackage

/* design/ilbm_body_rle_unpacker.sv */
// top level of the ilbm body run unpacker: byterun1 decoder with row clipping
// depends on ilbmrle_pkg
//
// usage:
//  in channel (in_valid/in_ready/data_byte) carries one body byte per transaction.
//  out channel (out_valid/out_ready) carries one run per transaction: pixel,
//  run_length, dest_offset, image_done and run_overflow. header bytes, discarded
//  literal bytes and clipped columns give no run.
//  config port (cfg_en/cfg_index/cfg_data) writes a register; write
//  only while no byte is in flight. sizes are clamped to 1..MAX as they are stored.
//  result: a run is registered and shows on the out channel in the cycle after its byte is taken.
//  throughput: one byte per cycle while in_ready is high; the state update and the run
//  are formed combinationally from the state registers into the result register.
//  stall: in_ready stays high while the result register is empty or being taken,
//  so a held result blocks the input only for the cycles that out_ready is low.
//  reset: registers return to their defaults (320 x 240, compressed), the decoder
//  waits for a header at row 0 column 0. after the last destination byte all
//  further bytes are taken and dropped until the next reset.
module ilbm_body_rle_unpacker #(
	parameter int MAX_WIDTH  = ilbmrle_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ilbmrle_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [ilbmrle_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ilbmrle_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [7:0]                          pixel,
	output logic [7:0]                          run_length,
	output logic [ilbmrle_pkg::OFS_W-1:0]       dest_offset,
	output logic                                image_done,
	output logic                                run_overflow
);
	import ilbmrle_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CS = (CW + 1 > 9) ? CW + 1 : 9;

	function automatic logic [CW-1:0] eff_w(input logic [CFG_DATA_W-1:0] v);
		if (v == '0)
			return CW'(1);
		else if (int'(v) > MAX_WIDTH)
			return CW'(MAX_WIDTH);
		else
			return CW'(v);
	endfunction

	function automatic logic [HW-1:0] eff_h(input logic [CFG_DATA_W-1:0] v);
		if (v == '0)
			return HW'(1);
		else if (int'(v) > MAX_HEIGHT)
			return HW'(MAX_HEIGHT);
		else
			return HW'(v);
	endfunction

	// configuration, stored already clamped
	logic [CW-1:0] sw_q, cw_q;
	logic [HW-1:0] sh_q, ch_q;
	logic          comp_q;

	// decoder state
	phase_t          phase_q, phase_n;
	logic [7:0]      lit_q, lit_n;
	logic [7:0]      rep_q, rep_n;
	logic [CW-1:0]   col_q, col_n;
	logic [HW-1:0]   row_q, row_n;
	logic [OFS_W-1:0] base_q, base_n;
	logic            fin_q, fin_n;

	// result register
	logic             out_valid_q;
	logic [7:0]       pixel_q, len_q;
	logic [OFS_W-1:0] ofs_q;
	logic             done_q, ovf_q;

	logic [CW-1:0]    ew;
	logic [HW-1:0]    eh;
	logic             in_fire;
	logic             wrap;
	logic [HW-1:0]    row0;
	logic [CW-1:0]    col0;
	logic [OFS_W-1:0] ofs;
	logic             last_row;
	logic [7:0]       lit_dec;
	logic [CW-1:0]    room, vis;
	logic [7:0]       rep_len, vis_len;
	logic             rep_ovf;
	logic             emit;
	logic [7:0]       o_len;
	logic             o_ovf, o_done;
	logic             adv;
	logic [7:0]       step_len;
	logic [CS-1:0]    col1;
	logic             nr;
	logic [1:0]       rows_add;
	logic [OFS_W-1:0] base_inc;

	assign ew = (sw_q < cw_q) ? sw_q : cw_q;
	assign eh = (sh_q < ch_q) ? sh_q : ch_q;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign wrap     = col_q >= sw_q;
	assign row0     = wrap ? row_q + HW'(1) : row_q;
	assign col0     = wrap ? '0 : col_q;
	assign ofs      = base_q + (wrap ? OFS_W'(ew) : OFS_W'(col_q));
	assign last_row = ({1'b0, row0} + (HW+1)'(1)) == {1'b0, eh};
	assign lit_dec  = lit_q - 8'd1;

	// repeat run: clamp to the source row and to the visible part
	assign room    = sw_q - col0;
	assign rep_len = ({{(CS-8){1'b0}}, rep_q} < CS'(room)) ? rep_q :
	                 ((CS'(room) == '0) ? 8'd1 : 8'(room));
	assign rep_ovf = {{(CS-8){1'b0}}, rep_q} > CS'(room);
	assign vis     = ew - col0;
	assign vis_len = ({{(CS-8){1'b0}}, rep_len} < CS'(vis)) ? rep_len : 8'(vis);

	assign col1   = CS'(col0) + CS'(step_len);
	assign o_done = last_row && ((CS'(col0) + CS'(o_len)) >= CS'(ew));

	always_comb begin
		phase_n  = phase_q;
		lit_n    = lit_q;
		rep_n    = rep_q;
		col_n    = col_q;
		row_n    = row_q;
		base_n   = base_q;
		fin_n    = fin_q;
		emit     = 1'b0;
		o_len    = 8'd1;
		o_ovf    = 1'b0;
		adv      = 1'b0;
		step_len = 8'd1;
		nr       = 1'b0;
		rows_add = 2'd0;
		base_inc = '0;
		if (!fin_q) begin
			if (row_q >= eh) begin
				fin_n = 1'b1;
			end else if (wrap && row0 >= eh) begin
				fin_n  = 1'b1;
				col_n  = '0;
				row_n  = row0;
				base_n = base_q + OFS_W'(ew);
			end else begin
				if (!comp_q) begin
					phase_n = PH_HEADER;
					lit_n   = '0;
					rep_n   = '0;
					adv     = 1'b1;
				end else begin
					case (phase_q)
						PH_HEADER: begin
							if (data_byte == HDR_NOP) begin
								phase_n = PH_HEADER;
							end else if (data_byte < HDR_NOP) begin
								lit_n   = data_byte + 8'd1;
								phase_n = PH_LITERAL;
							end else begin
								rep_n   = 8'(REP_BIAS - {1'b0, data_byte});
								phase_n = PH_REPEAT;
							end
						end
						PH_LITERAL: begin
							adv   = 1'b1;
							lit_n = lit_dec;
							o_ovf = (CS'(col0) + CS'(1) >= CS'(sw_q)) && (lit_dec != '0);
							if (lit_dec == '0)
								phase_n = PH_HEADER;
							if ((CS'(col0) + CS'(1) >= CS'(sw_q)) && (lit_dec != '0))
								phase_n = PH_DISCARD;
						end
						PH_REPEAT: begin
							adv      = 1'b1;
							step_len = rep_len;
							o_len    = vis_len;
							o_ovf    = rep_ovf;
							phase_n  = PH_HEADER;
							rep_n    = '0;
						end
						default: begin
							if (lit_q != '0)
								lit_n = lit_dec;
							if (lit_q == '0 || lit_dec == '0)
								phase_n = PH_HEADER;
						end
					endcase
				end
				if (adv) begin
					emit = col0 < ew;
					if (emit && o_done)
						fin_n = 1'b1;
					nr = !(emit && o_done) && (col1 >= CS'(sw_q));
				end
				rows_add = {1'b0, wrap} + {1'b0, nr};
				case (rows_add)
					2'd0:    base_inc = '0;
					2'd1:    base_inc = OFS_W'(ew);
					default: base_inc = OFS_W'(ew) << 1;
				endcase
				base_n = base_q + base_inc;
				row_n  = row0 + HW'(nr);
				if (nr)
					col_n = '0;
				else if (adv)
					col_n = col1[CW-1:0];
				else
					col_n = col0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q   <= eff_w(RST_SRC_WIDTH);
			sh_q   <= eff_h(RST_SRC_HEIGHT);
			cw_q   <= eff_w(RST_CLIP_WIDTH);
			ch_q   <= eff_h(RST_CLIP_HEIGHT);
			comp_q <= 1'b1;
		end else if (cfg_en) begin
			case (cfg_index)
				REG_SRC_WIDTH:   sw_q   <= eff_w(cfg_data);
				REG_SRC_HEIGHT:  sh_q   <= eff_h(cfg_data);
				REG_CLIP_WIDTH:  cw_q   <= eff_w(cfg_data);
				REG_CLIP_HEIGHT: ch_q   <= eff_h(cfg_data);
				REG_COMPRESSED:  comp_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			lit_q   <= '0;
			rep_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			base_q  <= '0;
			fin_q   <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_n;
			lit_q   <= lit_n;
			rep_q   <= rep_n;
			col_q   <= col_n;
			row_q   <= row_n;
			base_q  <= base_n;
			fin_q   <= fin_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			pixel_q <= data_byte;
			len_q   <= o_len;
			ofs_q   <= ofs;
			done_q  <= o_done;
			ovf_q   <= o_ovf;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel        = pixel_q;
	assign run_length   = len_q;
	assign dest_offset  = ofs_q;
	assign image_done   = done_q;
	assign run_overflow = ovf_q;

	a_fin_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> fin_q)
		else $error("finished flag cleared without reset");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (len_q != 8'd0) && (len_q <= 8'd128))
		else $error("run length out of range");

	a_done_fin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> fin_q)
		else $error("image done shown while decoder not finished");

	a_lit_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LITERAL) || (phase_q == PH_DISCARD) |-> lit_q != 8'd0)
		else $error("literal phase with nothing left");

endmodule

/* tb/sv/ilbm_run_check.sv */
// run checker for the ilbm body run unpacker: predicts the runs of a byterun1 body
// stream and compares them with the out channel
// depends on ilbmrle_pkg
module ilbm_run_check (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [ilbmrle_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ilbmrle_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [7:0]                          pixel,
	input  logic [7:0]                          run_length,
	input  logic [ilbmrle_pkg::OFS_W-1:0]       dest_offset,
	input  logic                                image_done,
	input  logic                                run_overflow,
	output int                                  mismatch_count,
	output int                                  runs_pending,
	output int                                  current_row
);
	timeunit 1ns;
	timeprecision 1ps;
	import ilbmrle_pkg::*;

	typedef struct packed {
		logic [7:0]       pixel;
		logic [7:0]       run_length;
		logic [OFS_W-1:0] dest_offset;
		logic             image_done;
		logic             run_overflow;
	} run_t;

	run_t expected_runs[$];
	int faults;

	logic [CFG_DATA_W-1:0] src_w, src_h, clip_w, clip_h;
	logic compressed;

	phase_t phase;
	int copy_left, repeat_left, col, row, row_base;
	bit image_closed;

	function automatic int eff_dim(input logic [CFG_DATA_W-1:0] v, input int limit);
		if (v == '0)
			return 1;
		return (int'(v) > limit) ? limit : int'(v);
	endfunction

	task automatic next_line(input int ew);
		col = 0;
		row = (row + 1) & 'h7FF;
		row_base = (row_base + ew) & 'hFFFFF;
	endtask

	task automatic queue_run(input logic [7:0] pix, input int len, input bit ovf,
			input int ew, input int eh);
		run_t r;
		r.pixel = pix;
		r.run_length = 8'(len);
		r.dest_offset = OFS_W'(row_base + col);
		r.image_done = (row + 1 == eh) && (col + len >= ew);
		r.run_overflow = ovf;
		if (r.image_done)
			image_closed = 1'b1;
		expected_runs.push_back(r);
	endtask

	task automatic decode_byte(input logic [7:0] b);
		int sw, cw, sh, ch, ew, eh, room, len, vis;
		bit ovf;
		sw = eff_dim(src_w, DEF_MAX_WIDTH);
		cw = eff_dim(clip_w, DEF_MAX_WIDTH);
		sh = eff_dim(src_h, DEF_MAX_HEIGHT);
		ch = eff_dim(clip_h, DEF_MAX_HEIGHT);
		ew = (sw < cw) ? sw : cw;
		eh = (sh < ch) ? sh : ch;
		if (image_closed)
			return;
		if (row >= eh) begin
			image_closed = 1'b1;
			return;
		end
		// a shrunk source width closes the row before this byte
		if (col >= sw) begin
			next_line(ew);
			if (row >= eh) begin
				image_closed = 1'b1;
				return;
			end
		end
		if (!compressed) begin
			phase = PH_HEADER;
			copy_left = 0;
			repeat_left = 0;
			if (col < ew)
				queue_run(b, 1, 1'b0, ew, eh);
			col++;
			if (!image_closed && col >= sw)
				next_line(ew);
			return;
		end
		case (phase)
			PH_HEADER: begin
				if (b != HDR_NOP) begin
					if (b < HDR_NOP) begin
						copy_left = int'(b) + 1;
						phase = PH_LITERAL;
					end else begin
						repeat_left = int'(REP_BIAS) - int'(b);
						phase = PH_REPEAT;
					end
				end
			end
			PH_LITERAL: begin
				copy_left = (copy_left - 1) & 'hFF;
				ovf = (col + 1 >= sw) && (copy_left > 0);
				if (col < ew)
					queue_run(b, 1, ovf, ew, eh);
				col++;
				if (copy_left == 0)
					phase = PH_HEADER;
				if (col >= sw) begin
					if (copy_left > 0)
						phase = PH_DISCARD;
					if (!image_closed)
						next_line(ew);
				end
			end
			PH_REPEAT: begin
				room = sw - col;
				len = (repeat_left < room) ? repeat_left : room;
				ovf = repeat_left > room;
				if (len == 0)
					len = 1;
				if (col < ew) begin
					vis = ew - col;
					queue_run(b, (len < vis) ? len : vis, ovf, ew, eh);
				end
				col += len;
				phase = PH_HEADER;
				repeat_left = 0;
				if (!image_closed && col >= sw)
					next_line(ew);
			end
			default: begin
				if (copy_left > 0)
					copy_left--;
				if (copy_left == 0)
					phase = PH_HEADER;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		run_t seen, want;
		if (!arst_n) begin
			src_w = RST_SRC_WIDTH;
			src_h = RST_SRC_HEIGHT;
			clip_w = RST_CLIP_WIDTH;
			clip_h = RST_CLIP_HEIGHT;
			compressed = 1'b1;
			phase = PH_HEADER;
			copy_left = 0;
			repeat_left = 0;
			col = 0;
			row = 0;
			row_base = 0;
			image_closed = 1'b0;
			faults = 0;
			expected_runs.delete();
			mismatch_count <= 0;
			runs_pending <= 0;
			current_row <= 0;
		end else begin
			if (cfg_en) begin
				case (cfg_index)
					REG_SRC_WIDTH:   src_w = cfg_data;
					REG_SRC_HEIGHT:  src_h = cfg_data;
					REG_CLIP_WIDTH:  clip_w = cfg_data;
					REG_CLIP_HEIGHT: clip_h = cfg_data;
					REG_COMPRESSED:  compressed = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				seen.pixel = pixel;
				seen.run_length = run_length;
				seen.dest_offset = dest_offset;
				seen.image_done = image_done;
				seen.run_overflow = run_overflow;
				if (expected_runs.size() == 0) begin
					if (faults < 10)
						$display("%0t: unexpected run pix=%h len=%0d ofs=%0d done=%b ovf=%b",
							$realtime, seen.pixel, seen.run_length, seen.dest_offset,
							seen.image_done, seen.run_overflow);
					faults++;
				end else begin
					want = expected_runs.pop_front();
					if (seen !== want) begin
						if (faults < 10) begin
							$write("%0t: run mismatch exp pix=%h len=%0d ofs=%0d done=%b ovf=%b",
								$realtime, want.pixel, want.run_length, want.dest_offset,
								want.image_done, want.run_overflow);
							$display(" got pix=%h len=%0d ofs=%0d done=%b ovf=%b",
								seen.pixel, seen.run_length, seen.dest_offset,
								seen.image_done, seen.run_overflow);
						end
						faults++;
					end
				end
			end
			if (in_valid && in_ready)
				decode_byte(data_byte);
			mismatch_count <= faults;
			runs_pending <= expected_runs.size();
			current_row <= row;
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// testbench top for the ilbm body run unpacker: drives byterun1 and raw body streams
// through several size settings with random idling on both channels
// depends on ilbmrle_pkg, ilbm_body_rle_unpacker and ilbm_run_check
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ilbmrle_pkg::*;

	localparam int STALL_LIMIT = 4000;

	logic clk, arst_n, cfg_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [7:0] data_byte, pixel, run_length;
	logic [OFS_W-1:0] dest_offset;
	logic image_done, run_overflow;
	int mismatch_count, runs_pending, current_row;

	bit steady = 1'b0;
	bit done_seen;
	int quiet_cycles = 0;

	// source width, source height, clip width, clip height, compressed, body bytes
	int plan_sw [10] = '{320, 2047, 7, 200, 16, 1, 0, 1024, 33, 1000};
	int plan_sh [10] = '{1024, 2047, 1024, 1024, 1024, 1024, 1024, 1024, 1024, 1024};
	int plan_cw [10] = '{320, 1024, 1024, 13, 9, 1, 1024, 1, 2047, 700};
	int plan_ch [10] = '{1024, 1024, 1025, 1024, 1024, 1024, 1024, 1024, 1024, 1024};
	int plan_comp [10] = '{1, 1, 1, 1, 0, 1, 1, 0, 1, 0};
	int plan_bytes [10] = '{250, 250, 150, 150, 120, 100, 80, 100, 150, 60};

	ilbm_body_rle_unpacker DUT (.*);
	ilbm_run_check run_check (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(1, 8);
		if (r < 92)
			return $urandom_range(9, 40);
		return $urandom_range(100, 128);
	endfunction

	function automatic logic [7:0] copy_header(input int count);
		return 8'(count - 1);
	endfunction

	function automatic logic [7:0] repeat_header(input int count);
		return 8'(int'(REP_BIAS) - count);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// mostly well-formed packets with random content, some stray bytes; only random bytes when raw_bytes is set
	task automatic send_stream(input int budget, input bit raw_bytes);
		int sent, pick, count;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (raw_bytes || pick < 6) begin
				send_byte(8'($urandom));
				sent++;
			end else if (pick < 10) begin
				send_byte(HDR_NOP);
				sent++;
			end else if (pick < 55) begin
				count = pick_count();
				send_byte(copy_header(count));
				repeat (count) send_byte(8'($urandom));
				sent += count + 1;
			end else begin
				count = pick_count();
				if (count < 2)
					count = 2;
				send_byte(repeat_header(count));
				send_byte(8'($urandom));
				sent += 2;
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (runs_pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input int value);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	task automatic load_setting(input int sw, input int sh, input int cw, input int ch,
			input int comp);
		put_reg(REG_SRC_WIDTH, sw);
		put_reg(REG_SRC_HEIGHT, sh);
		put_reg(REG_CLIP_WIDTH, cw);
		put_reg(REG_CLIP_HEIGHT, ch);
		put_reg(REG_COMPRESSED, comp);
		cfg_en <= 1'b0;
	endtask

	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			int hold, pause;
			hold = $urandom_range(1, 40);
			pause = pick_gap();
			if ($urandom_range(0, 9) == 0) begin
				hold = $urandom_range(100, 300);
				pause = 0;
			end
			out_ready <= 1'b1;
			repeat (hold) @(posedge clk);
			if (pause > 0) begin
				out_ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_seen <= 1'b0;
		else if (out_valid && out_ready && image_done)
			done_seen <= 1'b1;
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_en || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[ilbm_body_rle_unpacker] ERROR");
			$finish;
		end
	end

	initial begin
		int packets;
		arst_n <= 1'b0;
		cfg_en <= 1'b0;
		cfg_index <= REG_SRC_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset sizes: shortest and longest runs, no-op header
		send_byte(copy_header(1)); send_byte(8'h00);
		send_byte(repeat_header(2)); send_byte(8'hFF);
		send_byte(HDR_NOP);
		send_byte(repeat_header(128)); send_byte(8'hAA);
		send_byte(copy_header(2)); send_byte(8'h55); send_byte(8'hAA);
		drain();

		// narrow rows: width cut mid-row, repeat and literal past the row end
		load_setting(4, 1024, 1024, 1024, 1);
		send_byte(repeat_header(3)); send_byte(8'h11);
		send_byte(repeat_header(4)); send_byte(8'h22);
		send_byte(copy_header(6));
		send_byte(8'h01); send_byte(8'h02); send_byte(8'h04);
		send_byte(8'h08); send_byte(8'h10); send_byte(8'h20);
		drain();

		// raw bytes with the last columns clipped
		load_setting(4, 1024, 2, 1024, 0);
		send_byte(8'h80); send_byte(8'h7F); send_byte(8'h00); send_byte(8'hFF);

		for (int p = 0; p < 10; p++) begin
			drain();
			load_setting(plan_sw[p], plan_sh[p], plan_cw[p], plan_ch[p], plan_comp[p]);
			steady = ($urandom_range(0, 3) == 0);
			send_stream(plan_bytes[p], plan_comp[p] == 0);
		end

		// close the image a couple of rows on
		drain();
		load_setting(3, current_row + 3, 1024, 2047, 1);
		steady = 1'b0;
		packets = 0;
		while (!done_seen && packets < 200) begin
			send_stream(1, 1'b0);
			packets++;
		end
		drain();

		// bytes after the image are taken and dropped
		send_stream(12, 1'b0);
		drain();
		repeat (10) @(posedge clk);

		if (mismatch_count == 0 && runs_pending == 0 && done_seen)
			$display("[ilbm_body_rle_unpacker] OK");
		else
			$display("[ilbm_body_rle_unpacker] ERROR");
		$finish;
	end

endmodule
